>>> rtl/dpid_pkg.sv
// ----------------------------------------------------------------------------
// dpid_pkg
// Shared types, constants and helpers for the differential drive PID mixer.
// ----------------------------------------------------------------------------
package dpid_pkg;

    localparam int TICK_W      = 32;
    localparam int GAIN_W      = 24;
    localparam int PWM_W       = 16;
    localparam int CMD_W       = 15;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    localparam int GAIN_FRACTION_BITS_DEFAULT = 16;
    // Queue depth between front and back; must be a power of two.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P_DISTANCE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I_DISTANCE  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D_DISTANCE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P_ANGLE     = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I_ANGLE     = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D_ANGLE     = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_FULL_SCALE   = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_THRESHOLD = 8'd7;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] RST_GAIN_P_DISTANCE  = 24'd87381;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_DISTANCE  = 24'd131;
    localparam logic [GAIN_W-1:0] RST_GAIN_D_DISTANCE  = 24'd327680;
    localparam logic [GAIN_W-1:0] RST_GAIN_P_ANGLE     = 24'd131072;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_ANGLE     = 24'd131;
    localparam logic [GAIN_W-1:0] RST_GAIN_D_ANGLE     = 24'd327680;
    localparam logic [PWM_W-1:0]  RST_PWM_FULL_SCALE   = 16'd400;
    localparam logic [PWM_W-1:0]  RST_OFFSET_THRESHOLD = 16'd200;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p_distance;
        logic [GAIN_W-1:0] gain_i_distance;
        logic [GAIN_W-1:0] gain_d_distance;
        logic [GAIN_W-1:0] gain_p_angle;
        logic [GAIN_W-1:0] gain_i_angle;
        logic [GAIN_W-1:0] gain_d_angle;
        logic [PWM_W-1:0]  pwm_full_scale;
        logic [PWM_W-1:0]  offset_threshold;
    } cfg_t;

    // One classified tick as it travels from the front to the back.
    typedef struct packed {
        logic signed [TICK_W-1:0] distance_error;
        logic signed [TICK_W-1:0] heading_error;
        logic                     restart;
    } item_t;

    // Saturate a sign-extended value to signed 32 bits.
    function automatic logic signed [TICK_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sh0000_0000_7FFF_FFFF;
        min_v = -64'sh0000_0000_8000_0000;
        if (v > max_v) begin
            sat32 = max_v[TICK_W-1:0];
        end else if (v < min_v) begin
            sat32 = min_v[TICK_W-1:0];
        end else begin
            sat32 = v[TICK_W-1:0];
        end
    endfunction

endpackage

>>> rtl/differential_drive_pid_mixer.sv
// ----------------------------------------------------------------------------
// differential_drive_pid_mixer
// Dual PID (distance and heading) for a differential drive, mixed into
// left and right PWM commands.
// ----------------------------------------------------------------------------
// The block takes one control tick per clock cycle while the queue is not
// full and returns one result beat per tick, in order. A tick goes through
// the front in the cycle it is accepted, waits in a four-entry queue, and
// then crosses a seven-stage back pipeline (loop state, gain multipliers,
// sum, scaling, mixing, offset, clamp). The loop sums and previous errors
// are updated in the first back stage, which is what lets ticks follow each
// other every cycle while the back advances. When the result beat is not
// taken the back pipeline holds, and input beats are still taken until the
// queue is full. Configuration writes are taken every cycle and should only
// be made while no tick is in flight.
// ----------------------------------------------------------------------------
module differential_drive_pid_mixer #(
    parameter int GAIN_FRACTION_BITS = dpid_pkg::GAIN_FRACTION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH        = dpid_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dpid_pkg::CFG_INDEX_W-1:0]       cfg_addr,
    input  logic [dpid_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [dpid_pkg::TICK_W-1:0]     s_left_ticks,
    input  logic signed [dpid_pkg::TICK_W-1:0]     s_right_ticks,
    input  logic signed [dpid_pkg::TICK_W-1:0]     s_distance_goal,
    input  logic signed [dpid_pkg::TICK_W-1:0]     s_angle_goal,
    input  logic                                   s_restart,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [dpid_pkg::CMD_W-1:0]             m_left_command,
    output logic [dpid_pkg::CMD_W-1:0]             m_right_command,
    output logic signed [dpid_pkg::TICK_W-1:0]     m_distance_error_out,
    output logic signed [dpid_pkg::TICK_W-1:0]     m_angle_error_out
);
    import dpid_pkg::*;

    cfg_t  cfg_reg;
    item_t front_item;
    item_t queue_item;
    logic  queue_full;
    logic  queue_valid;
    logic  queue_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p_distance  <= RST_GAIN_P_DISTANCE;
            cfg_reg.gain_i_distance  <= RST_GAIN_I_DISTANCE;
            cfg_reg.gain_d_distance  <= RST_GAIN_D_DISTANCE;
            cfg_reg.gain_p_angle     <= RST_GAIN_P_ANGLE;
            cfg_reg.gain_i_angle     <= RST_GAIN_I_ANGLE;
            cfg_reg.gain_d_angle     <= RST_GAIN_D_ANGLE;
            cfg_reg.pwm_full_scale   <= RST_PWM_FULL_SCALE;
            cfg_reg.offset_threshold <= RST_OFFSET_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_GAIN_P_DISTANCE:  cfg_reg.gain_p_distance  <= cfg_data;
                REG_GAIN_I_DISTANCE:  cfg_reg.gain_i_distance  <= cfg_data;
                REG_GAIN_D_DISTANCE:  cfg_reg.gain_d_distance  <= cfg_data;
                REG_GAIN_P_ANGLE:     cfg_reg.gain_p_angle     <= cfg_data;
                REG_GAIN_I_ANGLE:     cfg_reg.gain_i_angle     <= cfg_data;
                REG_GAIN_D_ANGLE:     cfg_reg.gain_d_angle     <= cfg_data;
                REG_PWM_FULL_SCALE:   cfg_reg.pwm_full_scale   <= cfg_data[PWM_W-1:0];
                REG_OFFSET_THRESHOLD: cfg_reg.offset_threshold <= cfg_data[PWM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dpid_front u_front (
        .left_ticks    (s_left_ticks),
        .right_ticks   (s_right_ticks),
        .distance_goal (s_distance_goal),
        .heading_goal  (s_angle_goal),
        .restart       (s_restart),
        .item          (front_item)
    );

    assign s_ready = !queue_full;

    dpid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    dpid_back #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg_reg),
        .q_valid              (queue_valid),
        .q_item               (queue_item),
        .q_pop                (queue_pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_left_command       (m_left_command),
        .m_right_command      (m_right_command),
        .m_distance_error_out (m_distance_error_out),
        .m_angle_error_out    (m_angle_error_out)
    );

    // Reset leaves no result beat pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Both commands stay within half of the PWM full scale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_command <= cfg_reg.pwm_full_scale[PWM_W-1:1])
                 && (m_right_command <= cfg_reg.pwm_full_scale[PWM_W-1:1]))
        else $error("command above half of full scale");

    // The back only draws from the queue when it holds a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        queue_pop |-> queue_valid)
        else $error("pop from empty queue");

endmodule

>>> rtl/dpid_front.sv
// ----------------------------------------------------------------------------
// dpid_front
// Forms distance and heading from the wheel counts and the two errors.
// ----------------------------------------------------------------------------
module dpid_front (
    input  logic signed [dpid_pkg::TICK_W-1:0] left_ticks,
    input  logic signed [dpid_pkg::TICK_W-1:0] right_ticks,
    input  logic signed [dpid_pkg::TICK_W-1:0] distance_goal,
    input  logic signed [dpid_pkg::TICK_W-1:0] heading_goal,
    input  logic                               restart,
    output dpid_pkg::item_t                    item
);
    import dpid_pkg::*;

    logic signed [TICK_W:0]   wheel_sum;
    logic signed [TICK_W:0]   wheel_sum_rounded;
    logic signed [TICK_W:0]   distance;
    logic signed [TICK_W:0]   heading;
    logic signed [TICK_W+1:0] distance_error_wide;
    logic signed [TICK_W+1:0] heading_error_wide;

    assign wheel_sum = {left_ticks[TICK_W-1], left_ticks}
                     + {right_ticks[TICK_W-1], right_ticks};
    // Adding one to a negative sum before the shift truncates toward zero.
    assign wheel_sum_rounded = wheel_sum + $signed({{TICK_W{1'b0}}, wheel_sum[TICK_W]});
    assign distance = wheel_sum_rounded >>> 1;
    assign heading  = {right_ticks[TICK_W-1], right_ticks}
                    - {left_ticks[TICK_W-1], left_ticks};

    assign distance_error_wide = {{2{distance_goal[TICK_W-1]}}, distance_goal}
                               - {distance[TICK_W], distance};
    assign heading_error_wide  = {{2{heading_goal[TICK_W-1]}}, heading_goal}
                               - {heading[TICK_W], heading};

    assign item.distance_error = sat32({{(62-TICK_W){distance_error_wide[TICK_W+1]}},
                                        distance_error_wide});
    assign item.heading_error  = sat32({{(62-TICK_W){heading_error_wide[TICK_W+1]}},
                                        heading_error_wide});
    assign item.restart        = restart;

endmodule

>>> rtl/dpid_queue.sv
// ----------------------------------------------------------------------------
// dpid_queue
// Small register queue that decouples the front from the back pipeline.
// ----------------------------------------------------------------------------
module dpid_queue #(
    parameter int DEPTH = dpid_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dpid_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output dpid_pkg::item_t pop_item
);
    import dpid_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/dpid_back.sv
// ----------------------------------------------------------------------------
// dpid_back
// PID state update, gain products, scaling, mixing, offset and clamp.
// ----------------------------------------------------------------------------
module dpid_back #(
    parameter int GAIN_FRACTION_BITS = dpid_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  dpid_pkg::cfg_t                     cfg,
    input  logic                               q_valid,
    input  dpid_pkg::item_t                    q_item,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dpid_pkg::CMD_W-1:0]         m_left_command,
    output logic [dpid_pkg::CMD_W-1:0]         m_right_command,
    output logic signed [dpid_pkg::TICK_W-1:0] m_distance_error_out,
    output logic signed [dpid_pkg::TICK_W-1:0] m_angle_error_out
);
    import dpid_pkg::*;

    localparam int DELTA_W = TICK_W + 1;
    localparam int PE_W    = GAIN_W + 1 + TICK_W;
    localparam int PD_W    = GAIN_W + 1 + DELTA_W;
    localparam int ACC_W   = PD_W + 2;
    localparam int ADJ_W   = TICK_W + 3;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((64'd1 << GAIN_FRACTION_BITS) - 64'd1);

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_valid_reg;

    // Loop state.
    logic signed [TICK_W-1:0] dist_sum_reg, dist_prev_reg, ang_sum_reg, ang_prev_reg;
    logic signed [TICK_W-1:0] dist_sum_base, dist_prev_base, ang_sum_base, ang_prev_base;
    logic signed [TICK_W-1:0] dist_sum_next, ang_sum_next;
    logic signed [TICK_W:0]   dist_sum_wide, ang_sum_wide;

    // Errors ride alongside every stage.
    logic signed [TICK_W-1:0] derr1_reg, aerr1_reg, derr2_reg, aerr2_reg, derr3_reg, aerr3_reg;
    logic signed [TICK_W-1:0] derr4_reg, aerr4_reg, derr5_reg, aerr5_reg, derr6_reg, aerr6_reg;

    logic signed [TICK_W-1:0]  dsum1_reg, asum1_reg;
    logic signed [DELTA_W-1:0] ddelta1_reg, adelta1_reg;

    logic signed [PE_W-1:0] dp2_reg, di2_reg, ap2_reg, ai2_reg;
    logic signed [PD_W-1:0] dd2_reg, ad2_reg;

    logic signed [ACC_W-1:0] dacc3_reg, aacc3_reg;
    logic signed [ACC_W-1:0] dacc_biased, aacc_biased, dquot, aquot;

    logic signed [TICK_W-1:0] dcmd4_reg, acmd4_reg;
    logic signed [TICK_W:0]   left_wide, right_wide;
    logic signed [TICK_W-1:0] lcmd5_reg, rcmd5_reg;

    logic [CMD_W-1:0]         half;
    logic signed [TICK_W-1:0] hi, lo;
    logic signed [ADJ_W-1:0]  hi_ext, lo_ext, half_ext, thr_ext, offset_total;
    logic signed [ADJ_W-1:0]  ladj6_reg, radj6_reg, ladj_next, radj_next;

    logic [CMD_W-1:0] left_cmd_reg, right_cmd_reg;
    logic signed [TICK_W-1:0] derr_out_reg, aerr_out_reg;

    function automatic logic [CMD_W-1:0] clamp_cmd(input logic signed [ADJ_W-1:0] v,
                                                   input logic [CMD_W-1:0] lim);
        if (v < 0) begin
            clamp_cmd = '0;
        end else if (v > $signed({{(ADJ_W-CMD_W){1'b0}}, lim})) begin
            clamp_cmd = lim;
        end else begin
            clamp_cmd = v[CMD_W-1:0];
        end
    endfunction

    // The whole back pipeline moves together; it only stops when the result is held.
    assign advance = !m_valid_reg || m_ready;
    assign q_pop   = advance && q_valid;

    // Stage 1: restart, sum and delta against the loop state.
    assign dist_sum_base  = q_item.restart ? '0 : dist_sum_reg;
    assign dist_prev_base = q_item.restart ? '0 : dist_prev_reg;
    assign ang_sum_base   = q_item.restart ? '0 : ang_sum_reg;
    assign ang_prev_base  = q_item.restart ? '0 : ang_prev_reg;

    assign dist_sum_wide = {dist_sum_base[TICK_W-1], dist_sum_base}
                         + {q_item.distance_error[TICK_W-1], q_item.distance_error};
    assign ang_sum_wide  = {ang_sum_base[TICK_W-1], ang_sum_base}
                         + {q_item.heading_error[TICK_W-1], q_item.heading_error};
    assign dist_sum_next = sat32({{(63-TICK_W){dist_sum_wide[TICK_W]}}, dist_sum_wide});
    assign ang_sum_next  = sat32({{(63-TICK_W){ang_sum_wide[TICK_W]}}, ang_sum_wide});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_sum_reg  <= '0;
            dist_prev_reg <= '0;
            ang_sum_reg   <= '0;
            ang_prev_reg  <= '0;
        end else if (q_pop) begin
            dist_sum_reg  <= dist_sum_next;
            dist_prev_reg <= q_item.distance_error;
            ang_sum_reg   <= ang_sum_next;
            ang_prev_reg  <= q_item.heading_error;
        end
    end

    // Stage 4 arithmetic: divide by the gain scale, truncating toward zero.
    assign dacc_biased = dacc3_reg + (dacc3_reg[ACC_W-1] ? ROUND_BIAS : '0);
    assign aacc_biased = aacc3_reg + (aacc3_reg[ACC_W-1] ? ROUND_BIAS : '0);
    assign dquot       = dacc_biased >>> GAIN_FRACTION_BITS;
    assign aquot       = aacc_biased >>> GAIN_FRACTION_BITS;

    // Stage 5 arithmetic: mixing.
    assign left_wide  = {dcmd4_reg[TICK_W-1], dcmd4_reg} - {acmd4_reg[TICK_W-1], acmd4_reg};
    assign right_wide = {dcmd4_reg[TICK_W-1], dcmd4_reg} + {acmd4_reg[TICK_W-1], acmd4_reg};

    // Stage 6 arithmetic: both offsets use the unshifted extremes.
    assign half     = cfg.pwm_full_scale[PWM_W-1:1];
    assign hi       = (lcmd5_reg > rcmd5_reg) ? lcmd5_reg : rcmd5_reg;
    assign lo       = (lcmd5_reg > rcmd5_reg) ? rcmd5_reg : lcmd5_reg;
    assign hi_ext   = {{(ADJ_W-TICK_W){hi[TICK_W-1]}}, hi};
    assign lo_ext   = {{(ADJ_W-TICK_W){lo[TICK_W-1]}}, lo};
    assign half_ext = {{(ADJ_W-CMD_W){1'b0}}, half};
    assign thr_ext  = {{(ADJ_W-PWM_W){1'b0}}, cfg.offset_threshold};

    assign offset_total = ((hi_ext > thr_ext) ? (hi_ext - half_ext) : '0)
                        + ((lo_ext < -thr_ext) ? (lo_ext + half_ext) : '0);
    assign ladj_next = {{(ADJ_W-TICK_W){lcmd5_reg[TICK_W-1]}}, lcmd5_reg} - offset_total;
    assign radj_next = {{(ADJ_W-TICK_W){rcmd5_reg[TICK_W-1]}}, rcmd5_reg} - offset_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= q_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            m_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            derr1_reg   <= q_item.distance_error;
            aerr1_reg   <= q_item.heading_error;
            dsum1_reg   <= dist_sum_next;
            asum1_reg   <= ang_sum_next;
            ddelta1_reg <= {q_item.distance_error[TICK_W-1], q_item.distance_error}
                         - {dist_prev_base[TICK_W-1], dist_prev_base};
            adelta1_reg <= {q_item.heading_error[TICK_W-1], q_item.heading_error}
                         - {ang_prev_base[TICK_W-1], ang_prev_base};

            derr2_reg <= derr1_reg;
            aerr2_reg <= aerr1_reg;
            dp2_reg   <= PE_W'($signed({1'b0, cfg.gain_p_distance})) * PE_W'(derr1_reg);
            di2_reg   <= PE_W'($signed({1'b0, cfg.gain_i_distance})) * PE_W'(dsum1_reg);
            dd2_reg   <= PD_W'($signed({1'b0, cfg.gain_d_distance})) * PD_W'(ddelta1_reg);
            ap2_reg   <= PE_W'($signed({1'b0, cfg.gain_p_angle})) * PE_W'(aerr1_reg);
            ai2_reg   <= PE_W'($signed({1'b0, cfg.gain_i_angle})) * PE_W'(asum1_reg);
            ad2_reg   <= PD_W'($signed({1'b0, cfg.gain_d_angle})) * PD_W'(adelta1_reg);

            derr3_reg <= derr2_reg;
            aerr3_reg <= aerr2_reg;
            dacc3_reg <= {{(ACC_W-PE_W){dp2_reg[PE_W-1]}}, dp2_reg}
                       + {{(ACC_W-PE_W){di2_reg[PE_W-1]}}, di2_reg}
                       + {{(ACC_W-PD_W){dd2_reg[PD_W-1]}}, dd2_reg};
            aacc3_reg <= {{(ACC_W-PE_W){ap2_reg[PE_W-1]}}, ap2_reg}
                       + {{(ACC_W-PE_W){ai2_reg[PE_W-1]}}, ai2_reg}
                       + {{(ACC_W-PD_W){ad2_reg[PD_W-1]}}, ad2_reg};

            derr4_reg <= derr3_reg;
            aerr4_reg <= aerr3_reg;
            dcmd4_reg <= sat32(64'(dquot));
            acmd4_reg <= sat32(64'(aquot));

            derr5_reg <= derr4_reg;
            aerr5_reg <= aerr4_reg;
            lcmd5_reg <= sat32({{(63-TICK_W){left_wide[TICK_W]}}, left_wide});
            rcmd5_reg <= sat32({{(63-TICK_W){right_wide[TICK_W]}}, right_wide});

            derr6_reg <= derr5_reg;
            aerr6_reg <= aerr5_reg;
            ladj6_reg <= ladj_next;
            radj6_reg <= radj_next;

            derr_out_reg  <= derr6_reg;
            aerr_out_reg  <= aerr6_reg;
            left_cmd_reg  <= clamp_cmd(ladj6_reg, half);
            right_cmd_reg <= clamp_cmd(radj6_reg, half);
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_left_command       = left_cmd_reg;
    assign m_right_command      = right_cmd_reg;
    assign m_distance_error_out = derr_out_reg;
    assign m_angle_error_out    = aerr_out_reg;

endmodule
